FILE: src/rfp_pkg.sv
package rfp_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] pos_t;
    typedef logic [1:0] fstat_t;

    localparam byte_t HDR_FIRST   = 8'h55;
    localparam byte_t HDR_SECOND  = 8'hAA;
    localparam byte_t STATUS_GOOD = 8'h01;

    localparam pos_t POS_HDR_FIRST  = 3'd0;
    localparam pos_t POS_HDR_SECOND = 3'd1;
    localparam pos_t POS_STATUS     = 3'd3;
    localparam pos_t POS_DIST_HIGH  = 3'd5;
    localparam pos_t POS_DIST_LOW   = 3'd6;
    localparam pos_t POS_CHECKSUM   = 3'd7;

    localparam fstat_t FSTAT_VALID    = 2'd0;
    localparam fstat_t FSTAT_CHECKSUM = 2'd1;
    localparam fstat_t FSTAT_FAILED   = 2'd2;

endpackage

FILE: src/range_frame_parser.sv
// Path: checksum item -> input register -> result register -> out_valid.
// Throughput: one item per cycle; the input register advances unless it holds the checksum
// item while the result register is full and its item is not taken in the same cycle.
// Reset (rst_n low, asynchronous): input and result registers empty, frame position
// back to waiting for the first header byte, running sum zero.
module range_frame_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           frame_status,
    output logic [15:0]          distance_dm
);

    logic                 s1_valid_reg;
    rfp_pkg::byte_t       s1_byte_reg;

    rfp_pkg::pos_t        pos_reg;
    rfp_pkg::pos_t        pos_next;
    rfp_pkg::byte_t       sum_reg;
    rfp_pkg::byte_t       sum_next;
    rfp_pkg::byte_t       status_reg;
    rfp_pkg::byte_t       dist_hi_reg;
    rfp_pkg::byte_t       dist_lo_reg;

    logic                 out_valid_reg;
    rfp_pkg::fstat_t      fstat_reg;
    rfp_pkg::fstat_t      fstat_next;
    logic [15:0]          dist_reg;

    logic                 emit;
    logic                 out_free;
    logic                 s1_adv;
    logic                 s1_fire;

    assign emit     = s1_valid_reg && (pos_reg == rfp_pkg::POS_CHECKSUM);
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = !emit || out_free;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;

    assign out_valid    = out_valid_reg;
    assign frame_status = fstat_reg;
    assign distance_dm  = dist_reg;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        case (pos_reg)
            rfp_pkg::POS_HDR_FIRST:
            begin
                if (s1_byte_reg == rfp_pkg::HDR_FIRST)
                begin
                    pos_next = rfp_pkg::POS_HDR_SECOND;
                    sum_next = s1_byte_reg;
                end
            end
            rfp_pkg::POS_HDR_SECOND:
            begin
                if (s1_byte_reg == rfp_pkg::HDR_SECOND)
                begin
                    pos_next = pos_reg + 3'd1;
                    sum_next = sum_reg + s1_byte_reg;
                end
                else if (s1_byte_reg == rfp_pkg::HDR_FIRST)
                begin
                    pos_next = rfp_pkg::POS_HDR_SECOND;
                    sum_next = s1_byte_reg;
                end
                else
                begin
                    pos_next = rfp_pkg::POS_HDR_FIRST;
                    sum_next = '0;
                end
            end
            rfp_pkg::POS_CHECKSUM:
            begin
                pos_next = rfp_pkg::POS_HDR_FIRST;
                sum_next = '0;
            end
            default:
            begin
                pos_next = pos_reg + 3'd1;
                sum_next = sum_reg + s1_byte_reg;
            end
        endcase
    end

    always_comb
    begin
        if (sum_reg != s1_byte_reg)
        begin
            fstat_next = rfp_pkg::FSTAT_CHECKSUM;
        end
        else if (status_reg != rfp_pkg::STATUS_GOOD)
        begin
            fstat_next = rfp_pkg::FSTAT_FAILED;
        end
        else
        begin
            fstat_next = rfp_pkg::FSTAT_VALID;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= rfp_pkg::POS_HDR_FIRST;
            sum_reg <= '0;
        end
        else if (s1_fire)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            if (pos_reg == rfp_pkg::POS_STATUS)
            begin
                status_reg <= s1_byte_reg;
            end
            if (pos_reg == rfp_pkg::POS_DIST_HIGH)
            begin
                dist_hi_reg <= s1_byte_reg;
            end
            if (pos_reg == rfp_pkg::POS_DIST_LOW)
            begin
                dist_lo_reg <= s1_byte_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            fstat_reg <= fstat_next;
            dist_reg  <= {dist_hi_reg, dist_lo_reg};
        end
    end

endmodule
